// File: design/tcw_pkg.sv
// Text console writer package: shared types and fixed constants.
// No dependencies; imported by the controller and the top level.
package tcw_pkg;

    localparam int DATA_W    = 16;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int IDX_W     = 11;

    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] RESET_COLOR  = 8'h07;

    typedef enum logic [1:0] {
        OP_WRITE      = 2'd0,
        OP_CLEAR      = 2'd1,
        OP_READ       = 2'd2,
        OP_CLEAR_LINE = 2'd3
    } op_t;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EXEC   = 7'b0000010,
        S_READ   = 7'b0000100,
        S_SCROLL = 7'b0001000,
        S_DRAIN  = 7'b0010000,
        S_FILL   = 7'b0100000,
        S_PUT    = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        F_NONE = 2'd0,
        F_DONE = 2'd1,
        F_PUT  = 2'd2
    } follow_t;

    typedef struct packed {
        logic                 valid;
        logic [DATA_W-1:0]    data;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
    } res_t;

endpackage

// File: design/tcw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/tcw_ctrl.sv
// Text console controller: cursor, sequencer for write, scroll, fill and read.
// Depends on tcw_pkg; drives the cell RAM ports.
module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [1:0]                           op,
    input  logic [7:0]                           char_code,
    input  logic [IDX_W-1:0]                     cell_index,
    input  logic [7:0]                           text_color,
    output logic                                 busy,
    output logic                                 mem_we,
    output logic [$clog2(ROWS*COLUMNS)-1:0]      mem_waddr,
    output logic [DATA_W-1:0]                    mem_wdata,
    output logic                                 mem_re,
    output logic [$clog2(ROWS*COLUMNS)-1:0]      mem_raddr,
    input  logic [DATA_W-1:0]                    mem_rdata,
    output res_t                                 result
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int AW     = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int BASE_W = $clog2(CELLS + 1);
    localparam int IW     = (IDX_W > BASE_W) ? IDX_W : BASE_W;

    localparam logic [AW-1:0]     LAST_ADDR     = AW'(CELLS - 1);
    localparam logic [AW-1:0]     COPY_FIRST    = AW'(COLUMNS);
    localparam logic [BASE_W-1:0] COL_STEP      = BASE_W'(COLUMNS);
    localparam logic [BASE_W-1:0] COL_SPAN      = BASE_W'(COLUMNS - 1);
    localparam logic [BASE_W-1:0] LAST_ROW_BASE = BASE_W'((ROWS - 1) * COLUMNS);
    localparam logic [ROW_W-1:0]  ROW_LIM       = ROW_W'(ROWS);
    localparam logic [ROW_W-1:0]  ROW_LAST      = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LIM       = COL_W'(COLUMNS);
    localparam logic [IW-1:0]     CELL_LIM      = IW'(CELLS);

    state_t              state_reg,    state_next;
    follow_t             follow_reg,   follow_next;
    op_t                 op_reg,       op_next;
    logic [7:0]          ch_reg,       ch_next;
    logic [IDX_W-1:0]    idx_reg,      idx_next;
    logic [ROW_W-1:0]    row_reg,      row_next;
    logic [COL_W-1:0]    col_reg,      col_next;
    logic [BASE_W-1:0]   base_reg,     base_next;
    logic [AW-1:0]       src_reg,      src_next;
    logic [AW-1:0]       dst_reg,      dst_next;
    logic                cp_valid_reg, cp_valid_next;
    logic [AW-1:0]       cp_addr_reg,  cp_addr_next;
    logic [AW-1:0]       fill_addr_reg, fill_addr_next;
    logic [AW-1:0]       fill_end_reg, fill_end_next;
    logic                done_reg,     done_next;
    logic [DATA_W-1:0]   data_reg,     data_next;

    logic                wrap;
    logic                scroll_needed;
    logic [COL_W-1:0]    wrap_col;
    logic [BASE_W-1:0]   base_step;
    logic [BASE_W-1:0]   put_addr;
    logic [BASE_W-1:0]   put_addr_pend;
    logic                idx_ok;
    logic [7:0]          fill_color;

    assign wrap          = (col_reg >= COL_LIM);
    assign wrap_col      = wrap ? '0 : col_reg;
    assign scroll_needed = wrap ? (row_reg >= ROW_LAST) : (row_reg >= ROW_LIM);
    assign base_step     = base_reg + COL_STEP;
    assign put_addr      = wrap ? base_step : (base_reg + BASE_W'(col_reg));
    assign put_addr_pend = base_reg + BASE_W'(col_reg);
    assign idx_ok        = (IW'(idx_reg) < CELL_LIM);
    assign fill_color    = (follow_reg == F_NONE) ? RESET_COLOR : text_color;

    always_comb
    begin
        state_next     = state_reg;
        follow_next    = follow_reg;
        op_next        = op_reg;
        ch_next        = ch_reg;
        idx_next       = idx_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        cp_valid_next  = 1'b0;
        cp_addr_next   = cp_addr_reg;
        fill_addr_next = fill_addr_reg;
        fill_end_next  = fill_end_reg;
        done_next      = 1'b0;
        data_next      = data_reg;
        mem_we         = 1'b0;
        mem_waddr      = fill_addr_reg;
        mem_wdata      = {fill_color, BLANK_CHAR};
        mem_re         = 1'b0;
        mem_raddr      = src_reg;

        if (cp_valid_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = cp_addr_reg;
            mem_wdata = mem_rdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op_t'(op);
                    ch_next    = char_code;
                    idx_next   = cell_index;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_WRITE:
                    begin
                        if (ch_reg == NEWLINE_CHAR)
                        begin
                            col_next = '0;
                            if (row_reg >= ROW_LIM)
                            begin
                                follow_next = F_DONE;
                                src_next    = COPY_FIRST;
                                dst_next    = '0;
                                state_next  = S_SCROLL;
                            end
                            else
                            begin
                                row_next   = row_reg + 1'b1;
                                base_next  = base_step;
                                data_next  = '0;
                                done_next  = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else if (scroll_needed)
                        begin
                            row_next    = ROW_LAST;
                            base_next   = LAST_ROW_BASE;
                            col_next    = wrap_col;
                            follow_next = F_PUT;
                            src_next    = COPY_FIRST;
                            dst_next    = '0;
                            state_next  = S_SCROLL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(put_addr);
                            mem_wdata  = {text_color, ch_reg};
                            col_next   = wrap_col + 1'b1;
                            if (wrap)
                            begin
                                row_next  = row_reg + 1'b1;
                                base_next = base_step;
                            end
                            data_next  = '0;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    OP_CLEAR:
                    begin
                        row_next       = '0;
                        col_next       = '0;
                        base_next      = '0;
                        fill_addr_next = '0;
                        fill_end_next  = LAST_ADDR;
                        follow_next    = F_DONE;
                        state_next     = S_FILL;
                    end
                    OP_READ:
                    begin
                        if (idx_ok)
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = AW'(idx_reg);
                            state_next = S_READ;
                        end
                        else
                        begin
                            data_next  = '0;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    OP_CLEAR_LINE:
                    begin
                        col_next = '0;
                        if (row_reg < ROW_LIM)
                        begin
                            fill_addr_next = AW'(base_reg);
                            fill_end_next  = AW'(base_reg + COL_SPAN);
                            follow_next    = F_DONE;
                            state_next     = S_FILL;
                        end
                        else
                        begin
                            data_next  = '0;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_READ:
            begin
                data_next  = mem_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SCROLL:
            begin
                mem_re        = 1'b1;
                mem_raddr     = src_reg;
                cp_valid_next = 1'b1;
                cp_addr_next  = dst_reg;
                src_next      = src_reg + 1'b1;
                dst_next      = dst_reg + 1'b1;
                if (src_reg == LAST_ADDR)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                fill_addr_next = AW'(LAST_ROW_BASE);
                fill_end_next  = LAST_ADDR;
                state_next     = S_FILL;
            end
            S_FILL:
            begin
                mem_we         = 1'b1;
                mem_waddr      = fill_addr_reg;
                mem_wdata      = {fill_color, BLANK_CHAR};
                fill_addr_next = fill_addr_reg + 1'b1;
                if (fill_addr_reg == fill_end_reg)
                begin
                    unique case (follow_reg)
                        F_PUT:
                        begin
                            state_next = S_PUT;
                        end
                        F_DONE:
                        begin
                            data_next  = '0;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                    follow_next = F_DONE;
                end
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(put_addr_pend);
                mem_wdata  = {text_color, ch_reg};
                col_next   = col_reg + 1'b1;
                data_next  = '0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            follow_reg    <= F_NONE;
            op_reg        <= OP_WRITE;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            cp_valid_reg  <= 1'b0;
            cp_addr_reg   <= '0;
            fill_addr_reg <= '0;
            fill_end_reg  <= LAST_ADDR;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            follow_reg    <= follow_next;
            op_reg        <= op_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            cp_valid_reg  <= cp_valid_next;
            cp_addr_reg   <= cp_addr_next;
            fill_addr_reg <= fill_addr_next;
            fill_end_reg  <= fill_end_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        idx_reg  <= idx_next;
        data_reg <= data_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result.valid = done_reg;
    assign result.data  = data_reg;
    assign result.row   = ROW_OUT_W'(row_reg);
    assign result.col   = COL_OUT_W'(col_reg);

endmodule

// File: design/text_console_writer_unit.sv
// Text console writer: start is accepted while busy is low; done strobes one cycle, busy drops
// with it and the next transaction is accepted at the edge ending that cycle; no stall on done.
// A read beyond the store and a clear line with a scroll pending end without a RAM access; a
// scroll copies the rows up and blanks the last row before a pending character is written.
// Reset blanks the RAM to 0x0720 and holds busy high meanwhile. Depends on tcw_pkg, tcw_ctrl
// and tcw_ram.
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            op,
    input  logic [7:0]            char_code,
    input  logic [IDX_W-1:0]      cell_index,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_wdata,
    output logic                  done,
    output logic [DATA_W-1:0]     cell_data,
    output logic [ROW_OUT_W-1:0]  cursor_row,
    output logic [COL_OUT_W-1:0]  cursor_column
);

    localparam int AW = $clog2(ROWS * COLUMNS);

    logic [7:0]        text_color_reg, text_color_next;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    res_t              result;

    always_comb
    begin
        text_color_next = cfg_we ? cfg_wdata : text_color_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= RESET_COLOR;
        end
        else
        begin
            text_color_reg <= text_color_next;
        end
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (op),
        .char_code  (char_code),
        .cell_index (cell_index),
        .text_color (text_color_reg),
        .busy       (busy),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .result     (result)
    );

    tcw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ROWS * COLUMNS)
    ) u_cells (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign done          = result.valid;
    assign cell_data     = result.data;
    assign cursor_row    = result.row;
    assign cursor_column = result.col;

    a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done strobe while busy");

    a_done_single : assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted without going busy");

    a_cursor_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> ($stable(cursor_row) && $stable(cursor_column)))
        else $error("cursor moved while idle");

endmodule
